[sv/round_robin_slice_scheduler_unit_assert.svh]
// Assertion macros for the round-robin slice scheduler.
// Needs clk and rst_n in the scope of each use.
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RRSS_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("assertion failed");
`define RRSS_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("assertion failed");
`else
`define RRSS_ASSERT_IMP(lbl, ant, cons)
`define RRSS_ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

[sv/rrss_pkg.sv]
// Types, sizes and codes for the round-robin slice scheduler.
// No dependencies.
package rrss_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int QUANTUM_W = 16;
    localparam int BURST_W   = 16;
    localparam int CLOCK_W   = 24;
    localparam int WAIT_W    = 28;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [BURST_W-1:0] burst;
    } cmd_t;

    typedef struct packed {
        logic [3:0]         proc_index;
        logic [CLOCK_W-1:0] slice_start;
        logic [CLOCK_W-1:0] slice_end;
        logic               proc_finished;
        logic               all_done;
        logic [WAIT_W-1:0]  total_wait;
    } result_t;

    typedef struct packed {
        logic [BURST_W-1:0] remaining;
        logic [CLOCK_W-1:0] run_before;
    } entry_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } pick_t;

endpackage

[sv/rrss_entry_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module rrss_entry_ram #(
    parameter int DATA_W = 40,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/rrss_picker.sv]
// Rotating priority search for the next entry with work left.
// Depends on rrss_pkg.
module rrss_picker (
    input  logic [rrss_pkg::MAX_ENTRIES-1:0] avail,
    input  logic [rrss_pkg::IDX_W-1:0]       pos,
    output rrss_pkg::pick_t                  pick
);
    import rrss_pkg::*;

    logic [MAX_ENTRIES-1:0] upper;
    logic [IDX_W-1:0]       lo_idx;
    logic [IDX_W-1:0]       hi_idx;

    always_comb
    begin
        upper  = avail & ({MAX_ENTRIES{1'b1}} << pos);
        lo_idx = '0;
        hi_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                lo_idx = IDX_W'(i);
            end
            if (upper[i])
            begin
                hi_idx = IDX_W'(i);
            end
        end
        pick.found = |avail;
        pick.idx   = (|upper) ? hi_idx : lo_idx;
    end

endmodule

[sv/round_robin_slice_scheduler_unit.sv]
// Round-robin slice scheduler top level: command decode, slice update, result word.
// Depends on rrss_pkg, rrss_entry_ram, rrss_picker and the assertion header.
//
// A load or clear word gives no result; action 3 is dropped. A step word is
// handled first in ST_IDLE, which searches the work flags and reads the chosen
// entry from the entry RAM, then in ST_EXEC, which computes the slice and writes
// the entry back; busy is high in ST_EXEC. The result word is shown with
// result_strobe for exactly one cycle after ST_EXEC and cannot be held
// off, so a sink must take it then; a new word may be started in that cycle.
`include "round_robin_slice_scheduler_unit_assert.svh"
module round_robin_slice_scheduler_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rrss_pkg::cmd_t                cmd,
    output logic                          result_strobe,
    output rrss_pkg::result_t             result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rrss_pkg::QUANTUM_W-1:0] cfg_data
);
    import rrss_pkg::*;

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t                 state_reg, state_next;
    logic                   strobe_reg, strobe_next;
    result_t                result_reg, result_next;

    logic [QUANTUM_W-1:0]   quantum_reg, quantum_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       next_pos_reg, next_pos_next;
    logic [CLOCK_W-1:0]     clock_reg, clock_next;
    logic [WAIT_W-1:0]      wait_reg, wait_next;
    logic [MAX_ENTRIES-1:0] flags_reg, flags_next;
    pick_t                  pick_reg, pick_next;

    logic                   accept;
    logic [MAX_ENTRIES-1:0] avail;
    logic [IDX_W-1:0]       pos;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    entry_t                 ram_wdata;
    logic                   ram_re;
    entry_t                 ram_rdata;

    logic [QUANTUM_W-1:0]   q_eff;
    logic                   fin;
    logic [BURST_W-1:0]     slice;
    logic [CLOCK_W:0]       end_sum;
    logic [CLOCK_W-1:0]     slice_end;
    logic [CLOCK_W:0]       rb_sum;
    logic [CLOCK_W-1:0]     rb_new;
    logic [CLOCK_W-1:0]     wait_add;
    logic [WAIT_W:0]        wait_sum;
    logic [WAIT_W-1:0]      wait_new;
    logic [CNT_W-1:0]       idx_plus;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg == ST_EXEC);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            avail[i] = flags_reg[i] && (CNT_W'(i) < count_reg);
        end
        pos = (CNT_W'(next_pos_reg) < count_reg) ? next_pos_reg : '0;
    end

    rrss_picker u_picker (
        .avail (avail),
        .pos   (pos),
        .pick  (pick_next)
    );

    rrss_entry_ram #(
        .DATA_W ($bits(entry_t)),
        .DEPTH  (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pick_next.idx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        q_eff     = (quantum_reg == '0) ? QUANTUM_W'(1) : quantum_reg;
        fin       = (ram_rdata.remaining <= q_eff);
        slice     = fin ? ram_rdata.remaining : q_eff;
        end_sum   = {1'b0, clock_reg} + (CLOCK_W + 1)'(slice);
        slice_end = end_sum[CLOCK_W] ? {CLOCK_W{1'b1}} : end_sum[CLOCK_W-1:0];
        rb_sum    = {1'b0, ram_rdata.run_before} + (CLOCK_W + 1)'(slice);
        rb_new    = rb_sum[CLOCK_W] ? {CLOCK_W{1'b1}} : rb_sum[CLOCK_W-1:0];
        wait_add  = (clock_reg >= ram_rdata.run_before) ?
                    (clock_reg - ram_rdata.run_before) : '0;
        wait_sum  = {1'b0, wait_reg} + (WAIT_W + 1)'(wait_add);
        wait_new  = wait_sum[WAIT_W] ? {WAIT_W{1'b1}} : wait_sum[WAIT_W-1:0];
        idx_plus  = CNT_W'(pick_reg.idx) + CNT_W'(1);
    end

    always_comb
    begin
        state_next    = state_reg;
        strobe_next   = 1'b0;
        result_next   = result_reg;
        quantum_next  = quantum_reg;
        count_next    = count_reg;
        next_pos_next = next_pos_reg;
        clock_next    = clock_reg;
        wait_next     = wait_reg;
        flags_next    = flags_reg;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[IDX_W-1:0];
        ram_wdata     = '{remaining: cmd.burst, run_before: '0};
        ram_re        = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            quantum_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.action)
                        ACT_LOAD:
                        begin
                            if (count_reg < CNT_W'(MAX_ENTRIES))
                            begin
                                ram_we = 1'b1;
                                flags_next[count_reg[IDX_W-1:0]] = (cmd.burst != '0);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_STEP:
                        begin
                            ram_re     = 1'b1;
                            state_next = ST_EXEC;
                        end
                        ACT_CLEAR:
                        begin
                            count_next    = '0;
                            next_pos_next = '0;
                            clock_next    = '0;
                            wait_next     = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                state_next  = ST_IDLE;
                strobe_next = 1'b1;
                if (!pick_reg.found)
                begin
                    result_next = '{proc_index: '0, slice_start: '0, slice_end: '0,
                                    proc_finished: 1'b0, all_done: 1'b1,
                                    total_wait: wait_reg};
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pick_reg.idx;
                    clock_next = slice_end;
                    if (fin)
                    begin
                        ram_wdata = '{remaining: '0, run_before: ram_rdata.run_before};
                        flags_next[pick_reg.idx] = 1'b0;
                        wait_next = wait_new;
                    end
                    else
                    begin
                        ram_wdata = '{remaining: ram_rdata.remaining - slice,
                                      run_before: rb_new};
                    end
                    next_pos_next = (idx_plus >= count_reg) ? '0 : idx_plus[IDX_W-1:0];
                    result_next = '{proc_index: 4'(pick_reg.idx), slice_start: clock_reg,
                                    slice_end: slice_end, proc_finished: fin,
                                    all_done: 1'b0,
                                    total_wait: fin ? wait_new : wait_reg};
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            pick_reg <= pick_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg  <= QUANTUM_W'(1);
            count_reg    <= '0;
            next_pos_reg <= '0;
            clock_reg    <= '0;
            wait_reg     <= '0;
            flags_reg    <= '0;
        end
        else
        begin
            quantum_reg  <= quantum_next;
            count_reg    <= count_next;
            next_pos_reg <= next_pos_next;
            clock_reg    <= clock_next;
            wait_reg     <= wait_next;
            flags_reg    <= flags_next;
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    `RRSS_ASSERT_NEXT(a_exec_one_cycle, busy, !busy && result_strobe)
    `RRSS_ASSERT_IMP(a_strobe_after_exec, result_strobe, $past(busy))
    `RRSS_ASSERT_IMP(a_done_no_finish, result_strobe && result.all_done, !result.proc_finished)
    `RRSS_ASSERT_IMP(a_slice_order, result_strobe && !result.all_done,
                     result.slice_end >= result.slice_start)

endmodule
